// ===== design/lpcp_pkg.sv =====
// Package for the lidar point camera projection block.
// Holds register indexes, field widths and pipeline constants; no dependencies.
package lpcp_pkg;

  typedef enum logic [2:0] {
    REG_ROT_X  = 3'd0,
    REG_ROT_Y  = 3'd1,
    REG_ROT_Z  = 3'd2,
    REG_TRANS  = 3'd3,
    REG_DIST   = 3'd4,
    REG_FOCAL  = 3'd5,
    REG_PRINC  = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_t;

  localparam int PW  = 24;          // point field width
  localparam int CW  = 42;          // camera coordinate width, 14 fraction bits
  localparam int QB  = 21;          // quotient bits of the normalizing divide
  localparam int RW  = 64;          // divider remainder width
  localparam int DIV_STAGES = QB;
  localparam int NST = 3 + DIV_STAGES + 11;  // total register stages

  localparam logic signed [21:0] NORM_LIM = 22'sd1048576;
  localparam logic signed [39:0] DIST_LIM = 40'sd274877906944;

  typedef struct packed {
    logic behind;
    logic sat;
  } flags_t;

  typedef struct packed {
    logic behind;
    logic sx;
    logic sy;
    logic ovx;
    logic ovy;
  } div_side_t;

endpackage

// ===== design/lidar_point_camera_projection_top.sv =====
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall holds every stage in place.
// The normalizing divide takes one quotient bit per stage (21 stages).
// Synchronous active-low reset clears valid bits and loads identity rotation,
// all other configuration registers zero; pipeline data registers are not reset.
module lidar_point_camera_projection_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_u[15:0], pixel_v[31:16]
  output logic [1:0]  out_tuser   // in_front[0], saturated[1]
);

  localparam int L = lpcp_pkg::NST;
  localparam int D = lpcp_pkg::DIV_STAGES;

  // configuration
  logic [47:0] rot_r [3];
  logic [62:0] trans_r;
  logic [63:0] dist_r;
  logic [47:0] focal_r;
  logic [47:0] princ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 48'd16384;
      rot_r[1] <= 48'd16384 << 16;
      rot_r[2] <= 48'd16384 << 32;
      trans_r  <= '0;
      dist_r   <= '0;
      focal_r  <= '0;
      princ_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (lpcp_pkg::reg_idx_t'(cfg_addr))
        lpcp_pkg::REG_ROT_X: rot_r[0] <= cfg_wdata[47:0];
        lpcp_pkg::REG_ROT_Y: rot_r[1] <= cfg_wdata[47:0];
        lpcp_pkg::REG_ROT_Z: rot_r[2] <= cfg_wdata[47:0];
        lpcp_pkg::REG_TRANS: trans_r  <= cfg_wdata[62:0];
        lpcp_pkg::REG_DIST:  dist_r   <= cfg_wdata;
        lpcp_pkg::REG_FOCAL: focal_r  <= cfg_wdata[47:0];
        lpcp_pkg::REG_PRINC: princ_r  <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] k1, k2, p1, p2;
  assign k1 = dist_r[15:0];
  assign k2 = dist_r[31:16];
  assign p1 = dist_r[47:32];
  assign p2 = dist_r[63:48];

  // pipeline control
  logic [L-1:0] v_r;
  logic         ce;

  assign ce        = !v_r[L-1] || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[L-2:0], in_tvalid};
    end
  end

  // stage 1: rotation products
  logic signed [39:0] m_r [3][3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= $signed(rot_r[i][16*j +: 16]) * $signed(in_tdata[24*j +: 24]);
        end
      end
    end
  end

  // stage 2: sums and translation
  logic signed [lpcp_pkg::CW-1:0] c_r [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= lpcp_pkg::CW'(m_r[i][0]) + lpcp_pkg::CW'(m_r[i][1])
                + lpcp_pkg::CW'(m_r[i][2])
                + (lpcp_pkg::CW'($signed(trans_r[21*i +: 21])) <<< 14);
      end
    end
  end

  // stage 3 and divide stages: one quotient bit per stage
  logic [lpcp_pkg::RW-1:0] remx_r [D+1];
  logic [lpcp_pkg::RW-1:0] remy_r [D+1];
  logic [lpcp_pkg::QB-1:0] qx_r   [D+1];
  logic [lpcp_pkg::QB-1:0] qy_r   [D+1];
  logic [40:0]             dz_r   [D+1];
  lpcp_pkg::div_side_t     ds_r   [D+1];

  logic [40:0] ax, ay, az;
  logic        bh;
  always_comb begin
    ax = c_r[0][lpcp_pkg::CW-1] ? 41'(-c_r[0]) : 41'(c_r[0]);
    ay = c_r[1][lpcp_pkg::CW-1] ? 41'(-c_r[1]) : 41'(c_r[1]);
    az = 41'(c_r[2]);
    bh = (c_r[2] <= 0);
  end

  logic [lpcp_pkg::RW-1:0] shd  [D];
  logic                    tx   [D];
  logic                    ty   [D];
  always_comb begin
    for (int k = 0; k < D; k++) begin
      shd[k] = lpcp_pkg::RW'(dz_r[k]) << (D - 1 - k);
      tx[k]  = remx_r[k] >= shd[k];
      ty[k]  = remy_r[k] >= shd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      remx_r[0]   <= {7'd0, ax, 16'd0};
      remy_r[0]   <= {7'd0, ay, 16'd0};
      qx_r[0]     <= '0;
      qy_r[0]     <= '0;
      dz_r[0]     <= az;
      ds_r[0].behind <= bh;
      ds_r[0].sx  <= c_r[0][lpcp_pkg::CW-1];
      ds_r[0].sy  <= c_r[1][lpcp_pkg::CW-1];
      ds_r[0].ovx <= ({5'd0, ax} >= {az, 5'd0});
      ds_r[0].ovy <= ({5'd0, ay} >= {az, 5'd0});
      for (int k = 0; k < D; k++) begin
        remx_r[k+1] <= tx[k] ? remx_r[k] - shd[k] : remx_r[k];
        remy_r[k+1] <= ty[k] ? remy_r[k] - shd[k] : remy_r[k];
        qx_r[k+1]   <= qx_r[k] | (lpcp_pkg::QB'(tx[k]) << (D - 1 - k));
        qy_r[k+1]   <= qy_r[k] | (lpcp_pkg::QB'(ty[k]) << (D - 1 - k));
        dz_r[k+1]   <= dz_r[k];
        ds_r[k+1]   <= ds_r[k];
      end
    end
  end

  // clamp and sign of normalized coordinates
  logic signed [21:0] x25_r, y25_r;
  lpcp_pkg::flags_t   f25_r;
  logic               clx, cly;
  logic signed [21:0] nx, ny;
  always_comb begin
    clx = ds_r[D].ovx || (qx_r[D] > 21'd1048576);
    cly = ds_r[D].ovy || (qy_r[D] > 21'd1048576);
    nx  = clx ? lpcp_pkg::NORM_LIM : $signed({1'b0, qx_r[D]});
    ny  = cly ? lpcp_pkg::NORM_LIM : $signed({1'b0, qy_r[D]});
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x25_r <= ds_r[D].sx ? -nx : nx;
      y25_r <= ds_r[D].sy ? -ny : ny;
      f25_r.behind <= ds_r[D].behind;
      f25_r.sat    <= clx || cly;
    end
  end

  // squares and cross product
  logic signed [43:0] xx26_r, yy26_r, xy26_r;
  logic signed [21:0] x26_r, y26_r;
  lpcp_pkg::flags_t   f26_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      xx26_r <= x25_r * x25_r;
      yy26_r <= y25_r * y25_r;
      xy26_r <= x25_r * y25_r;
      x26_r  <= x25_r;
      y26_r  <= y25_r;
      f26_r  <= f25_r;
    end
  end

  // scale down to Q.16
  logic signed [29:0] r2_27_r;
  logic signed [27:0] xx27_r, yy27_r, xy27_r;
  logic signed [21:0] x27_r, y27_r;
  lpcp_pkg::flags_t   f27_r;
  logic signed [44:0] sq_sum;
  assign sq_sum = 45'(xx26_r) + 45'(yy26_r);
  always_ff @(posedge clk) begin
    if (ce) begin
      r2_27_r <= 30'(sq_sum >>> 16);
      xx27_r  <= 28'(xx26_r >>> 16);
      yy27_r  <= 28'(yy26_r >>> 16);
      xy27_r  <= 28'(xy26_r >>> 16);
      x27_r   <= x26_r;
      y27_r   <= y26_r;
      f27_r   <= f26_r;
    end
  end

  // radial and tangential products
  logic signed [59:0] r4f28_r;
  logic signed [45:0] k1r2_28_r;
  logic signed [46:0] t1x28_r, t2y28_r;
  logic signed [48:0] t2x28_r, t1y28_r;
  logic signed [21:0] x28_r, y28_r;
  lpcp_pkg::flags_t   f28_r;
  logic signed [31:0] sxx, syy;
  always_comb begin
    sxx = 32'(r2_27_r) + (32'(xx27_r) <<< 1);
    syy = 32'(r2_27_r) + (32'(yy27_r) <<< 1);
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      r4f28_r   <= r2_27_r * r2_27_r;
      k1r2_28_r <= 46'(k1 * r2_27_r);
      t1x28_r   <= 47'(p1 * xy27_r);
      t2y28_r   <= 47'(p2 * xy27_r);
      t2x28_r   <= 49'(p2 * sxx);
      t1y28_r   <= 49'(p1 * syy);
      x28_r     <= x27_r;
      y28_r     <= y27_r;
      f28_r     <= f27_r;
    end
  end

  // k2 * r4
  logic signed [59:0] k2r4_29_r;
  logic signed [45:0] k1r2_29_r;
  logic signed [46:0] t1x29_r, t2y29_r;
  logic signed [48:0] t2x29_r, t1y29_r;
  logic signed [21:0] x29_r, y29_r;
  lpcp_pkg::flags_t   f29_r;
  logic signed [43:0] r4;
  assign r4 = 44'(r4f28_r >>> 16);
  always_ff @(posedge clk) begin
    if (ce) begin
      k2r4_29_r <= k2 * r4;
      k1r2_29_r <= k1r2_28_r;
      t1x29_r   <= t1x28_r;
      t2y29_r   <= t2y28_r;
      t2x29_r   <= t2x28_r;
      t1y29_r   <= t1y28_r;
      x29_r     <= x28_r;
      y29_r     <= y28_r;
      f29_r     <= f28_r;
    end
  end

  // radial factor
  logic signed [38:0] rad30_r;
  logic signed [46:0] t1x30_r, t2y30_r;
  logic signed [48:0] t2x30_r, t1y30_r;
  logic signed [21:0] x30_r, y30_r;
  lpcp_pkg::flags_t   f30_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      rad30_r <= 39'(49'sd65536 + 49'(k1r2_29_r >>> 12) + 49'(k2r4_29_r >>> 12));
      t1x30_r <= t1x29_r;
      t2y30_r <= t2y29_r;
      t2x30_r <= t2x29_r;
      t1y30_r <= t1y29_r;
      x30_r   <= x29_r;
      y30_r   <= y29_r;
      f30_r   <= f29_r;
    end
  end

  // coordinate times radial factor
  logic signed [60:0] xr31_r, yr31_r;
  logic signed [46:0] t1x31_r, t2y31_r;
  logic signed [48:0] t2x31_r, t1y31_r;
  lpcp_pkg::flags_t   f31_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      xr31_r  <= x30_r * rad30_r;
      yr31_r  <= y30_r * rad30_r;
      t1x31_r <= t1x30_r;
      t2y31_r <= t2y30_r;
      t2x31_r <= t2x30_r;
      t1y31_r <= t1y30_r;
      f31_r   <= f30_r;
    end
  end

  // distorted coordinates, clamp
  logic signed [46:0] xds, yds;
  logic               cdx, cdy;
  always_comb begin
    xds = 47'(xr31_r >>> 16) + 47'($signed({t1x31_r, 1'b0}) >>> 12)
        + 47'(t2x31_r >>> 12);
    yds = 47'(yr31_r >>> 16) + 47'(t1y31_r >>> 12)
        + 47'($signed({t2y31_r, 1'b0}) >>> 12);
    cdx = (xds > 47'(lpcp_pkg::DIST_LIM)) || (xds < -47'(lpcp_pkg::DIST_LIM));
    cdy = (yds > 47'(lpcp_pkg::DIST_LIM)) || (yds < -47'(lpcp_pkg::DIST_LIM));
  end

  logic signed [39:0] xd32_r, yd32_r;
  lpcp_pkg::flags_t   f32_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      xd32_r <= (xds > 47'(lpcp_pkg::DIST_LIM)) ? lpcp_pkg::DIST_LIM :
                (xds < -47'(lpcp_pkg::DIST_LIM)) ? -lpcp_pkg::DIST_LIM : 40'(xds);
      yd32_r <= (yds > 47'(lpcp_pkg::DIST_LIM)) ? lpcp_pkg::DIST_LIM :
                (yds < -47'(lpcp_pkg::DIST_LIM)) ? -lpcp_pkg::DIST_LIM : 40'(yds);
      f32_r.behind <= f31_r.behind;
      f32_r.sat    <= f31_r.sat || cdx || cdy;
    end
  end

  // focal scaling
  logic signed [64:0] pu33_r, pv33_r;
  lpcp_pkg::flags_t   f33_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      pu33_r <= $signed({1'b0, focal_r[23:0]}) * xd32_r;
      pv33_r <= $signed({1'b0, focal_r[47:24]}) * yd32_r;
      f33_r  <= f32_r;
    end
  end

  // principal point offset, magnitude
  logic signed [64:0] accu, accv;
  assign accu = pu33_r + 65'($signed({1'b0, princ_r[23:0], 16'd0}));
  assign accv = pv33_r + 65'($signed({1'b0, princ_r[47:24], 16'd0}));

  logic [64:0]      mu34_r, mv34_r;
  logic             su34_r, sv34_r;
  lpcp_pkg::flags_t f34_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      mu34_r <= accu[64] ? 65'(-accu) : 65'(accu);
      mv34_r <= accv[64] ? 65'(-accv) : 65'(accv);
      su34_r <= accu[64];
      sv34_r <= accv[64];
      f34_r  <= f33_r;
    end
  end

  // round half away from zero, clamp to 16 bits
  logic [41:0]  qu, qv;
  logic         cpu, cpv;
  logic [15:0]  pu, pv;
  always_comb begin
    qu  = 42'((mu34_r + 65'd8388608) >> 24);
    qv  = 42'((mv34_r + 65'd8388608) >> 24);
    cpu = su34_r ? (qu > 42'd32768) : (qu > 42'd32767);
    cpv = sv34_r ? (qv > 42'd32768) : (qv > 42'd32767);
    if (cpu)         pu = su34_r ? 16'h8000 : 16'h7fff;
    else if (su34_r) pu = 16'(-qu);
    else             pu = qu[15:0];
    if (cpv)         pv = sv34_r ? 16'h8000 : 16'h7fff;
    else if (sv34_r) pv = 16'(-qv);
    else             pv = qv[15:0];
  end

  logic [31:0] od_r;
  logic [1:0]  ou_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      if (f34_r.behind) begin
        od_r <= 32'hffff_ffff;
        ou_r <= 2'b00;
      end else begin
        od_r <= {pv, pu};
        ou_r <= {f34_r.sat || cpu || cpv, 1'b1};
      end
    end
  end

  assign out_tvalid = v_r[L-1];
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

`ifndef ASSERT_OFF
  a_ready_ce: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");

  a_behind_pix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 32'hffff_ffff && !out_tuser[1]))
    else $error("behind-camera result not -1 or flagged saturated");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted beat not captured");
`endif

endmodule

// ===== tb/lidar_point_camera_projection_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lidar_point_camera_projection_top: projects each
// accepted point in a scoreboard model and compares every output beat.
// Depends on lpcp_pkg and the top level RTL.
module lidar_point_camera_projection_top_tb;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    bit          front;
    bit          sat;
  } pixel_t;

  class projection_board;
    logic [63:0] regs [7];
    pixel_t      pending[$];
    int          errors;

    function new();
      regs[lpcp_pkg::REG_ROT_X] = 64'd16384;
      regs[lpcp_pkg::REG_ROT_Y] = 64'd16384 << 16;
      regs[lpcp_pkg::REG_ROT_Z] = 64'd16384 << 32;
      for (int i = 3; i < 7; i++) regs[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(lpcp_pkg::reg_idx_t idx, logic [63:0] val);
      unique case (idx)
        lpcp_pkg::REG_ROT_X, lpcp_pkg::REG_ROT_Y, lpcp_pkg::REG_ROT_Z,
        lpcp_pkg::REG_FOCAL, lpcp_pkg::REG_PRINC: regs[idx] = {16'd0, val[47:0]};
        lpcp_pkg::REG_TRANS: regs[idx] = {1'b0, val[62:0]};
        lpcp_pkg::REG_DIST:  regs[idx] = val;
        default: ;
      endcase
    endfunction

    function longint coef(logic [63:0] r, int i);
      return longint'($signed(r[16*i +: 16]));
    endfunction

    function longint rotate(logic [63:0] row, longint p0, longint p1, longint p2, int ti);
      longint t;
      t = longint'($signed(regs[lpcp_pkg::REG_TRANS][21*ti +: 21]));
      return coef(row, 0) * p0 + coef(row, 1) * p1 + coef(row, 2) * p2 + t * 16384;
    endfunction

    function longint normalize(longint c, longint depth, inout bit sat);
      longint num;
      longint unsigned mag, q;
      num = c * 65536;
      mag = num < 0 ? longint'(-num) : num;
      q = mag / longint'(depth);
      if (q > 64'd1048576) begin
        sat = 1;
        q = 64'd1048576;
      end
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp_dist(longint d, inout bit sat);
      longint lim;
      lim = longint'(1) << 38;
      if (d > lim) begin
        sat = 1;
        return lim;
      end
      if (d < -lim) begin
        sat = 1;
        return -lim;
      end
      return d;
    endfunction

    function longint scale_pixel(longint d, logic [23:0] f, logic [23:0] c, inout bit sat);
      longint acc, q;
      longint unsigned mag;
      acc = longint'(f) * d + longint'(c) * 65536;
      mag = acc < 0 ? longint'(-acc) : acc;
      q = longint'((mag + (64'd1 << 23)) >> 24);
      if (acc < 0) q = -q;
      if (q > 32767) begin
        sat = 1;
        q = 32767;
      end
      if (q < -32768) begin
        sat = 1;
        q = -32768;
      end
      return q;
    endfunction

    function void note_point(logic [71:0] d);
      longint p0, p1, p2, cx, cy, cz, x, y, r2, r4, rad, xy, xx, yy, xd, yd;
      longint k1, k2, t1, t2, u, v;
      bit sat;
      pixel_t e;
      sat = 0;
      p0 = longint'($signed(d[23:0]));
      p1 = longint'($signed(d[47:24]));
      p2 = longint'($signed(d[71:48]));
      cx = rotate(regs[lpcp_pkg::REG_ROT_X], p0, p1, p2, 0);
      cy = rotate(regs[lpcp_pkg::REG_ROT_Y], p0, p1, p2, 1);
      cz = rotate(regs[lpcp_pkg::REG_ROT_Z], p0, p1, p2, 2);
      if (cz <= 0) begin
        e = '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0};
      end else begin
        x = normalize(cx, cz, sat);
        y = normalize(cy, cz, sat);
        k1 = coef(regs[lpcp_pkg::REG_DIST], 0);
        k2 = coef(regs[lpcp_pkg::REG_DIST], 1);
        t1 = coef(regs[lpcp_pkg::REG_DIST], 2);
        t2 = coef(regs[lpcp_pkg::REG_DIST], 3);
        r2 = (x * x + y * y) >>> 16;
        r4 = (r2 * r2) >>> 16;
        rad = 65536 + ((k1 * r2) >>> 12) + ((k2 * r4) >>> 12);
        xy = (x * y) >>> 16;
        xx = (x * x) >>> 16;
        yy = (y * y) >>> 16;
        xd = ((x * rad) >>> 16) + ((2 * t1 * xy) >>> 12) + ((t2 * (r2 + 2 * xx)) >>> 12);
        yd = ((y * rad) >>> 16) + ((t1 * (r2 + 2 * yy)) >>> 12) + ((2 * t2 * xy) >>> 12);
        xd = clamp_dist(xd, sat);
        yd = clamp_dist(yd, sat);
        u = scale_pixel(xd, regs[lpcp_pkg::REG_FOCAL][23:0],
                        regs[lpcp_pkg::REG_PRINC][23:0], sat);
        v = scale_pixel(yd, regs[lpcp_pkg::REG_FOCAL][47:24],
                        regs[lpcp_pkg::REG_PRINC][47:24], sat);
        e = '{u[15:0], v[15:0], 1'b1, sat};
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_pixel(logic [31:0] d, logic [1:0] user);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat u=%h v=%h user=%b", d[15:0], d[31:16], user);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.u) begin
        $error("pixel_u expected %h actual %h", e.u, d[15:0]);
        errors++;
      end
      if (d[31:16] !== e.v) begin
        $error("pixel_v expected %h actual %h", e.v, d[31:16]);
        errors++;
      end
      if (user[0] !== e.front) begin
        $error("in_front expected %b actual %b", e.front, user[0]);
        errors++;
      end
      if (user[1] !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  bit          quiet = 0;

  projection_board board = new();

  lidar_point_camera_projection_top i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_point(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_pixel(out_tdata, out_tuser);
  end

  // output-side stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_tready = 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready = 1;
      end
    end
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic write_reg(lpcp_pkg::reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en = 1;
    cfg_addr = idx;
    cfg_wdata = val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  // drop valid, then hold until every expected beat has come
  task automatic drain();
    in_tvalid = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (lpcp_pkg::NST + 10) @(posedge clk);
  endtask

  // caller stands just after a falling edge or at the start of one
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {z, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] near_one(int spread);
    return 16'(16384 + $urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic camera_setup(int heavy);
    int k;
    write_reg(lpcp_pkg::REG_ROT_X, {16'(0), near_one(0) - 16'd16384
                                    + 16'($urandom_range(0, 200)) - 16'd100,
                                    16'd0, near_one(100)} & 64'hFFFF_FFFF_FFFF);
    write_reg(lpcp_pkg::REG_ROT_Y, {16'd0, 16'($urandom_range(0, 200)) - 16'd100,
                                    near_one(100),
                                    16'($urandom_range(0, 200)) - 16'd100});
    write_reg(lpcp_pkg::REG_ROT_Z, {16'd0, near_one(100),
                                    16'($urandom_range(0, 200)) - 16'd100,
                                    16'($urandom_range(0, 200)) - 16'd100});
    write_reg(lpcp_pkg::REG_TRANS, {1'b0, 21'($urandom_range(0, 4000)) - 21'd2000,
                                    21'($urandom_range(0, 4000)) - 21'd2000,
                                    21'($urandom_range(0, 4000)) - 21'd2000});
    k = heavy ? 30000 : 1500;
    write_reg(lpcp_pkg::REG_DIST, {16'($urandom_range(0, 2 * k) - k),
                                   16'($urandom_range(0, 2 * k) - k),
                                   16'($urandom_range(0, 2 * k) - k),
                                   16'($urandom_range(0, 2 * k) - k)});
    write_reg(lpcp_pkg::REG_FOCAL,
              {24'($urandom_range(200, 2000) << 8) | 24'($urandom_range(0, 255)),
               24'($urandom_range(200, 2000) << 8) | 24'($urandom_range(0, 255))});
    write_reg(lpcp_pkg::REG_PRINC, {24'($urandom_range(0, 1200) << 8),
                                    24'($urandom_range(0, 1200) << 8)});
  endtask

  task automatic random_points(int n);
    logic [23:0] x, y, z;
    int zi;
    repeat (n) begin
      if ($urandom_range(0, 9) < 3) begin
        x = 24'($urandom);
        y = 24'($urandom);
        z = 24'($urandom);
      end else begin
        zi = $urandom_range(256, 200000);
        z = 24'(zi);
        x = 24'($signed($urandom_range(0, 4 * zi)) - 2 * zi);
        y = 24'($signed($urandom_range(0, 4 * zi)) - 2 * zi);
        if ($urandom_range(0, 15) == 0) z = -z;
      end
      send_point(x, y, z);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset values, then a plain camera for the directed points
    random_points(30);
    drain();
    camera_setup(0);
    @(negedge clk);
    send_point(24'h000000, 24'h000000, 24'h000000);  // depth zero
    send_point(24'h000000, 24'h000000, 24'h000001);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);  // behind
    send_point(24'h7FFFFF, 24'h800000, 24'h000400);  // normalize clamps
    send_point(24'h800000, 24'h7FFFFF, 24'h000400);
    send_point(24'h000000, 24'h000000, 24'h7FFFFF);
    send_point(24'h000000, 24'h000000, 24'hFFFFFF);
    send_point(24'h000400, 24'hFFFC00, 24'h002800);
    send_point(24'hFFFC00, 24'h000400, 24'h002800);
    send_point(24'h001000, 24'h001000, 24'h000800);
    send_point(24'h7FFFFF, 24'h000000, 24'h000002);
    send_point(24'h000000, 24'h7FFFFF, 24'h000002);
    send_point(24'h555555, 24'hAAAAAA, 24'h555555);
    send_point(24'hAAAAAA, 24'h555555, 24'h2AAAAA);
    send_point(24'h000001, 24'hFFFFFF, 24'h100000);
    random_points(200);
    drain();

    // strong distortion, large angles push the pixel clamp
    camera_setup(1);
    @(negedge clk);
    random_points(250);
    drain();

    // fully random registers, index past the last register too
    for (int i = 0; i < 8; i++) write_reg(lpcp_pkg::reg_idx_t'(i), rnd64());
    @(negedge clk);
    random_points(250);
    drain();

    // all ones
    for (int i = 0; i < 7; i++) write_reg(lpcp_pkg::reg_idx_t'(i), '1);
    @(negedge clk);
    random_points(150);
    drain();

    // all zeros
    for (int i = 0; i < 7; i++) write_reg(lpcp_pkg::reg_idx_t'(i), '0);
    @(negedge clk);
    random_points(100);
    drain();

    // plain camera, no idling on either side
    camera_setup(0);
    quiet = 1;
    @(negedge clk);
    random_points(450);
    in_tvalid = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (lpcp_pkg::NST + 10) @(posedge clk);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
